// ===== design/crcfpb_pkg.sv =====
// shared types, constants and the crc byte update for the framed packet builder
package crcfpb_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_VERSION = 2'd2;

  // item kinds on the input
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  // byte slots of a header command
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_SYNC1   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SYNC2   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_VERSION = 4'd2;
  localparam logic [STEP_W-1:0] STEP_TYPE    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SEQ0    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SEQ1    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SEQ2    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_SEQ3    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_TICK0   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_TICK1   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_TICK2   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_TICK3   = 4'd11;
  localparam logic [STEP_W-1:0] STEP_LEN_LO  = 4'd12;
  localparam logic [STEP_W-1:0] STEP_LEN_HI  = 4'd13;
  localparam logic [STEP_W-1:0] STEP_CRC_LO  = 4'd14;
  localparam logic [STEP_W-1:0] STEP_CRC_HI  = 4'd15;

  // byte slots of a payload command
  localparam logic [STEP_W-1:0] DSTEP_DATA   = 4'd0;
  localparam logic [STEP_W-1:0] DSTEP_CRC_LO = 4'd1;
  localparam logic [STEP_W-1:0] DSTEP_CRC_HI = 4'd2;

  typedef enum logic [1:0] {
    CMD_FAULT = 2'd0,
    CMD_START = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  frame_type;
    logic [31:0] sequence_req;
    logic [31:0] tick_ms;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_frame;
    logic       fault;
  } out_item_t;

  // classified work for the back end
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  frame_type;
    logic [31:0] sequence_req;
    logic [31:0] tick_ms;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic        last;       // start: empty payload, data: final payload byte
  } cmd_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } q_status_t;

  // crc-16/ccitt-false, one byte msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/crcfpb_front.sv =====
// front end: accepts input words, tracks frame position, classifies each word
module crcfpb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  crcfpb_pkg::in_item_t in_word,
  input  logic                 q_full,
  output logic                 push,
  output crcfpb_pkg::cmd_t     cmd
);
  import crcfpb_pkg::*;

  logic        payload_active;
  logic [15:0] bytes_left;
  logic        payload_active_next;
  logic [15:0] bytes_left_next;

  assign push = in_valid && !q_full;

  always_comb begin
    cmd.frame_type     = in_word.frame_type;
    cmd.sequence_req   = in_word.sequence_req;
    cmd.tick_ms        = in_word.tick_ms;
    cmd.payload_length = in_word.payload_length;
    cmd.data_byte      = in_word.data_byte;
    cmd.kind           = CMD_FAULT;
    cmd.last           = 1'b0;
    payload_active_next = payload_active;
    bytes_left_next     = bytes_left;
    if (in_word.func == FUNC_START) begin
      if (!payload_active) begin
        cmd.kind = CMD_START;
        cmd.last = (in_word.payload_length == 16'd0);
        payload_active_next = (in_word.payload_length != 16'd0);
        bytes_left_next     = in_word.payload_length;
      end
    end else begin
      if (payload_active) begin
        cmd.kind = CMD_DATA;
        cmd.last = (bytes_left == 16'd1);
        bytes_left_next     = bytes_left - 16'd1;
        payload_active_next = (bytes_left != 16'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_active <= 1'b0;
      bytes_left     <= 16'd0;
    end else if (push) begin
      payload_active <= payload_active_next;
      bytes_left     <= bytes_left_next;
    end
  end

endmodule

// ===== design/crcfpb_fifo.sv =====
// short command queue between front and back
module crcfpb_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  crcfpb_pkg::cmd_t      push_cmd,
  input  logic                  pop,
  output crcfpb_pkg::cmd_t      head,
  output crcfpb_pkg::q_status_t status
);
  import crcfpb_pkg::*;

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head              = mem[rd_ptr];
  assign status.full       = (count == QCNT_W'(QDEPTH));
  assign status.head_valid = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/crcfpb_back.sv =====
// back end: expands commands into output bytes and runs the crc
module crcfpb_back (
  input  logic                  clk,
  input  logic                  rst,
  input  crcfpb_pkg::cmd_t      head,
  input  logic                  head_valid,
  input  logic [7:0]            sync_first,
  input  logic [7:0]            sync_second,
  input  logic [7:0]            format_version,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output crcfpb_pkg::out_item_t out_word
);
  import crcfpb_pkg::*;

  logic [STEP_W-1:0] step;
  logic [15:0]       crc;
  logic              can_load;
  logic              fire;
  logic [7:0]        byte_val;
  logic              feed;
  logic              last_frame;
  logic              fault_flag;
  logic              final_step;

  assign can_load = !out_valid || !out_stall;
  assign fire     = head_valid && can_load;
  assign pop      = fire && final_step;

  always_comb begin
    byte_val   = 8'h00;
    feed       = 1'b0;
    last_frame = 1'b0;
    fault_flag = 1'b0;
    final_step = 1'b1;
    case (head.kind)
      CMD_START: begin
        final_step = head.last ? (step == STEP_CRC_HI) : (step == STEP_LEN_HI);
        feed = (step >= STEP_VERSION) && (step <= STEP_LEN_HI);
        case (step)
          STEP_SYNC1:   byte_val = sync_first;
          STEP_SYNC2:   byte_val = sync_second;
          STEP_VERSION: byte_val = format_version;
          STEP_TYPE:    byte_val = head.frame_type;
          STEP_SEQ0:    byte_val = head.sequence_req[7:0];
          STEP_SEQ1:    byte_val = head.sequence_req[15:8];
          STEP_SEQ2:    byte_val = head.sequence_req[23:16];
          STEP_SEQ3:    byte_val = head.sequence_req[31:24];
          STEP_TICK0:   byte_val = head.tick_ms[7:0];
          STEP_TICK1:   byte_val = head.tick_ms[15:8];
          STEP_TICK2:   byte_val = head.tick_ms[23:16];
          STEP_TICK3:   byte_val = head.tick_ms[31:24];
          STEP_LEN_LO:  byte_val = head.payload_length[7:0];
          STEP_LEN_HI:  byte_val = head.payload_length[15:8];
          STEP_CRC_LO:  byte_val = crc[7:0];
          STEP_CRC_HI: begin
            byte_val   = crc[15:8];
            last_frame = 1'b1;
          end
          default: byte_val = 8'h00;
        endcase
      end
      CMD_DATA: begin
        final_step = head.last ? (step == DSTEP_CRC_HI) : (step == DSTEP_DATA);
        case (step)
          DSTEP_DATA: begin
            byte_val = head.data_byte;
            feed     = 1'b1;
          end
          DSTEP_CRC_LO: byte_val = crc[7:0];
          DSTEP_CRC_HI: begin
            byte_val   = crc[15:8];
            last_frame = 1'b1;
          end
          default: byte_val = 8'h00;
        endcase
      end
      CMD_FAULT: begin
        fault_flag = 1'b1;
      end
      default: begin
        fault_flag = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      crc       <= CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        step <= final_step ? '0 : step + 1'b1;
        if (head.kind == CMD_START && step == STEP_SYNC1) begin
          crc <= CRC_INIT;
        end else if (feed) begin
          crc <= crc_feed(crc, byte_val);
        end else if (last_frame) begin
          crc <= CRC_INIT;
        end
      end
      if (can_load) begin
        out_valid <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word.out_byte      <= byte_val;
      out_word.last_of_frame <= last_frame;
      out_word.fault         <= fault_flag;
    end
  end

endmodule

// ===== design/crc16_framed_packet_builder_top.sv =====
// top level of the crc-16 framed packet builder
//
// input channel (in_valid / in_stall / in_word): one word per item. a start
// word (func 0) opens a frame and yields 14 output words: two sync bytes,
// version, type, sequence and tick (little-endian), length (little-endian).
// with a zero length the two crc bytes follow at once, 16 words in all.
// a payload word (func 1) yields its data byte, plus the two crc bytes (low
// first, last_of_frame on the high one) after the final byte of the frame.
// a word out of turn yields one word with fault set and out_byte 0.
// output channel (out_valid / out_stall / out_word): one byte per word.
// an accepted word is written into the command queue, and its output
// words are registered from the queue head. throughput: one output word
// per cycle while out_stall is low, set by the back end issuing one byte
// a cycle; so payload words but a frame's last stream at one per cycle.
// config port (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
// index 0 sync_first, 1 sync_second, 2 format_version; others ignored.
// reset (synchronous, rst high): frame state idle, queue empty, crc 0xffff,
// config back to 0xaa, 0x55, 0x01.
// when the receiver stalls the output word holds, the two-entry command
// queue fills, and in_stall then rises until the back end drains it.
module crc16_framed_packet_builder_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  crcfpb_pkg::in_item_t                  in_word,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output crcfpb_pkg::out_item_t                 out_word,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [crcfpb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                            cfg_data
);
  import crcfpb_pkg::*;

  // configuration registers
  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic [7:0] format_version;

  // front to queue
  logic      push;
  cmd_t      push_cmd;
  // queue to back
  cmd_t      head;
  q_status_t q_status;
  logic      pop;

  assign cfg_ready = 1'b1;
  // front only takes a word when the queue has room
  assign in_stall  = q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first     <= 8'hAA;
      sync_second    <= 8'h55;
      format_version <= 8'h01;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SYNC_FIRST:     sync_first     <= cfg_data;
        CFG_SYNC_SECOND:    sync_second    <= cfg_data;
        CFG_FORMAT_VERSION: format_version <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify each word against the frame position
  crcfpb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_word  (in_word),
    .q_full   (q_status.full),
    .push     (push),
    .cmd      (push_cmd)
  );

  // decouples the input from the byte sequencer
  crcfpb_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // one byte a cycle while out_stall is low, crc updated alongside
  crcfpb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .head_valid     (q_status.head_valid),
    .sync_first     (sync_first),
    .sync_second    (sync_second),
    .format_version (format_version),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word)
  );

endmodule

// ===== tb/crc16_framed_packet_builder_top_tb.sv =====
// self-checking testbench for the crc-16 framed packet builder
module crc16_framed_packet_builder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crcfpb_pkg::*;

  localparam int CLK_PERIOD = 10;
  // run limit, with room for every word sixteen bytes behind the heaviest stall mix
  localparam int MAX_CYCLES = 200000;
  // receiver hold-off that fills the command queue and backs up the input
  localparam int LONG_HOLD = 200;
  // cycles let pass before a register write and at the end of the run
  localparam int DRAIN_PAD = 8;
  // index past the last register, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int STRAY_PCT = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // every block input starts from a known value
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  crc16_framed_packet_builder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // words waiting for the driver, and framed bytes the block still owes
  in_item_t  words_to_send[$];
  out_item_t bytes_due[$];

  // idle mix of the current phase, in percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // long receiver hold-off: the stimulus bumps the request count, the stall
  // process notices the change and counts the stretch down by itself
  int rx_hold_req = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;

  int words_queued = 0;
  int words_taken = 0;
  int bytes_checked = 0;
  int faults_due = 0;
  int fail_count = 0;
  int cycle_count = 0;
  logic in_took = 1'b0;

  // predictor copy of the registers and the frame state
  logic [7:0]  sync_first_q = 8'hAA;
  logic [7:0]  sync_second_q = 8'h55;
  logic [7:0]  format_version_q = 8'h01;
  logic        frame_open = 1'b0;
  logic [15:0] frame_crc = CRC_INIT;
  logic [15:0] frame_left = '0;

  // stimulus-side mirror of whether a frame is open, to shape the sequences
  logic        gen_open = 1'b0;
  int          gen_left = 0;

  // crc-16/ccitt-false over one byte, msb first, no reflection
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    repeat (8) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  task automatic owe_byte(input logic [7:0] b, input logic covered);
    out_item_t o;
    if (covered) begin
      frame_crc = crc16_step(frame_crc, b);
    end
    o.out_byte = b;
    o.last_of_frame = 1'b0;
    o.fault = 1'b0;
    bytes_due.push_back(o);
  endtask

  // crc low byte, then high byte flagged as end of frame; back to idle
  task automatic owe_crc_and_close();
    out_item_t o;
    o.out_byte = frame_crc[7:0];
    o.last_of_frame = 1'b0;
    o.fault = 1'b0;
    bytes_due.push_back(o);
    o.out_byte = frame_crc[15:8];
    o.last_of_frame = 1'b1;
    bytes_due.push_back(o);
    frame_open = 1'b0;
    frame_left = '0;
    frame_crc = CRC_INIT;
  endtask

  // out-of-turn word: dropped, one zero byte with fault set
  task automatic owe_fault();
    out_item_t o;
    o.out_byte = 8'h00;
    o.last_of_frame = 1'b0;
    o.fault = 1'b1;
    bytes_due.push_back(o);
    faults_due++;
  endtask

  // works out every framed byte that one accepted input word causes
  task automatic build_frame_bytes(input in_item_t w);
    if (w.func == FUNC_START) begin
      if (frame_open) begin
        owe_fault();
      end else begin
        frame_crc = CRC_INIT;
        // sync bytes stay outside the crc, version starts it
        owe_byte(sync_first_q, 1'b0);
        owe_byte(sync_second_q, 1'b0);
        owe_byte(format_version_q, 1'b1);
        owe_byte(w.frame_type, 1'b1);
        for (int i = 0; i < 4; i++) owe_byte(w.sequence_req[8*i +: 8], 1'b1);
        for (int i = 0; i < 4; i++) owe_byte(w.tick_ms[8*i +: 8], 1'b1);
        owe_byte(w.payload_length[7:0], 1'b1);
        owe_byte(w.payload_length[15:8], 1'b1);
        if (w.payload_length == 16'd0) begin
          // empty frame closes right after the header
          owe_crc_and_close();
        end else begin
          frame_open = 1'b1;
          frame_left = w.payload_length;
        end
      end
    end else if (!frame_open) begin
      owe_fault();
    end else begin
      owe_byte(w.data_byte, 1'b1);
      frame_left = frame_left - 16'd1;
      if (frame_left == 16'd0) begin
        owe_crc_and_close();
      end
    end
  endtask

  // start word; fields of the other kind carry random junk
  task automatic queue_start(input logic [7:0] ftype, input logic [31:0] seq,
                             input logic [31:0] tick, input logic [15:0] len);
    in_item_t w;
    w.func = FUNC_START;
    w.frame_type = ftype;
    w.sequence_req = seq;
    w.tick_ms = tick;
    w.payload_length = len;
    w.data_byte = 8'($urandom_range(255));
    words_to_send.push_back(w);
    words_queued++;
    if (!gen_open && len != 16'd0) begin
      gen_open = 1'b1;
      gen_left = len;
    end
  endtask

  task automatic queue_data(input logic [7:0] b);
    in_item_t w;
    w.func = FUNC_DATA;
    w.frame_type = 8'($urandom_range(255));
    w.sequence_req = $urandom;
    w.tick_ms = $urandom;
    w.payload_length = 16'($urandom_range(65535));
    w.data_byte = b;
    words_to_send.push_back(w);
    words_queued++;
    if (gen_open) begin
      gen_left--;
      if (gen_left == 0) gen_open = 1'b0;
    end
  endtask

  task automatic queue_random_start();
    int unsigned pick;
    logic [15:0] len;
    pick = $urandom_range(99);
    // mostly short frames, some empty, a few longer
    if (pick < 15) len = 16'd0;
    else if (pick < 80) len = 16'($urandom_range(6, 1));
    else if (pick < 95) len = 16'($urandom_range(32, 7));
    else len = 16'($urandom_range(96, 33));
    queue_start(8'($urandom_range(255)), $urandom, $urandom, len);
  endtask

  // well-formed frames with random content, salted with out-of-turn words
  task automatic queue_random_words(input int n);
    for (int k = 0; k < n; k++) begin
      if (gen_open) begin
        if ($urandom_range(99) < STRAY_PCT) queue_random_start();
        else queue_data(8'($urandom_range(255)));
      end else begin
        if ($urandom_range(99) < STRAY_PCT) queue_data(8'($urandom_range(255)));
        else queue_random_start();
      end
    end
  endtask

  task automatic close_open_frame();
    while (gen_open) queue_data(8'($urandom_range(255)));
  endtask

  // returns at a falling edge once every word is taken and every byte seen
  task automatic wait_drained();
    do @(negedge clk); while (!(words_taken == words_queued && bytes_due.size() == 0));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SYNC_FIRST: begin
        sync_first_q = val;
      end
      CFG_SYNC_SECOND: begin
        sync_second_q = val;
      end
      CFG_FORMAT_VERSION: begin
        format_version_q = val;
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // registers change only with the block idle and all bytes accounted for
  task automatic set_framing(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [7:0] ver);
    wait_drained();
    repeat (DRAIN_PAD) @(negedge clk);
    write_reg(CFG_SYNC_FIRST, s1);
    write_reg(CFG_SYNC_SECOND, s2);
    write_reg(CFG_FORMAT_VERSION, ver);
    write_reg(CFG_SPARE, 8'($urandom_range(255)));
  endtask

  // input driver: a word stays put until it is taken
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_took)) begin
      if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_word <= words_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall: random per phase, or a long counted hold-off on request
  always @(negedge clk) begin
    if (rx_hold_seen != rx_hold_req) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = LONG_HOLD;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // input acceptance feeds the predictor, output words are checked in order
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        words_taken++;
        build_frame_bytes(in_word);
      end
      if (out_valid && !out_stall) begin
        bytes_checked++;
        if (bytes_due.size() == 0) begin
          $error("unexpected output word: out_byte %h last_of_frame %b fault %b",
                 out_word.out_byte, out_word.last_of_frame, out_word.fault);
          fail_count++;
        end else begin
          want = bytes_due.pop_front();
          if (out_word.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, out_word.out_byte);
            fail_count++;
          end
          if (out_word.last_of_frame !== want.last_of_frame) begin
            $error("last_of_frame: expected %b, actual %b",
                   want.last_of_frame, out_word.last_of_frame);
            fail_count++;
          end
          if (out_word.fault !== want.fault) begin
            $error("fault: expected %b, actual %b", want.fault, out_word.fault);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("crc16_framed_packet_builder_top_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words under the reset register values
    @(posedge clk);
    queue_data(8'hFF);                                       // payload while idle
    queue_start(8'h00, 32'h0000_0000, 32'h0000_0000, 16'h0000);   // empty frame, all zero
    queue_start(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);   // empty frame, all ones
    queue_start(8'h3C, 32'h1234_5678, 32'h89AB_CDEF, 16'h0003);
    queue_data(8'h00);
    queue_start(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);   // start inside a frame
    queue_data(8'hFF);
    queue_data(8'h5A);                                       // closes the frame
    queue_start(8'h81, 32'h0000_0001, 32'h8000_0000, 16'h0001);   // single-byte frame
    queue_data(8'hA5);
    queue_start(8'h7E, 32'h0000_0100, 32'hDEAD_0001, 16'h0002);
    queue_data(8'h01);
    queue_data(8'h80);
    queue_data(8'h33);                                       // payload after close
    wait_drained();

    // receiver holds off while the sender keeps offering a long frame
    @(posedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rx_hold_req++;
    queue_start(8'($urandom_range(255)), $urandom, $urandom, 16'd48);
    repeat (48) queue_data(8'($urandom_range(255)));
    wait_drained();

    // one longer frame under new registers, streamed without gaps
    set_framing(8'h00, 8'hFF, 8'h80);
    @(posedge clk);
    queue_start(8'($urandom_range(255)), $urandom, $urandom, 16'd24);
    repeat (24) queue_data(8'($urandom_range(255)));
    wait_drained();

    // random phases, one idle mix each, registers changed in between
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_framing(8'h00, 8'h00, 8'h00);
        1: set_framing(8'hFF, 8'hFF, 8'hFF);
        2: set_framing(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
        default: set_framing(8'hAA, 8'h55, 8'h01);
      endcase
      @(posedge clk);
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct = 28;
          recv_stall_pct = 28;
        end
      endcase
      queue_random_words(28);
      // sender pauses, often in mid-frame, until everything is out
      wait_drained();
      @(posedge clk);
      queue_random_words(28);
      close_open_frame();
      wait_drained();
    end

    repeat (DRAIN_PAD) @(negedge clk);
    $display("covered %0d input words (%0d out of turn), %0d output words checked",
             words_taken, faults_due, bytes_checked);
    $display("incl. empty frames, a long output hold-off, five register sets");
    if (fail_count == 0 && bytes_due.size() == 0) begin
      $display("crc16_framed_packet_builder_top_tb: clean");
    end else begin
      $display("crc16_framed_packet_builder_top_tb: errors");
    end
    $finish;
  end

endmodule
